// ===== design/text_line_justifier_top_macros.svh =====
// Assertion macros for the checker file of the justifier.
`ifndef TEXT_LINE_JUSTIFIER_TOP_MACROS_SVH
`define TEXT_LINE_JUSTIFIER_TOP_MACROS_SVH

// Clocked property with reset disable.
`define TLJ_ASSERT_CLK(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// Same-cycle implication.
`define TLJ_ASSERT_IMPL(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/tlj_pkg.sv =====
// Shared constants and controller/datapath interface types for the justifier.
package tlj_pkg;

  localparam int LW = 6;             // line/word length and width register bits
  localparam int GW = 5;             // gap count bits
  localparam int CW = 8;             // character bits
  localparam int MAX_WIDTH_DEF = 60;
  localparam logic [LW-1:0] LINE_WIDTH_RST = 6'd60;
  localparam logic [LW-1:0] MIN_WIDTH = 6'd2;

  localparam logic [CW-1:0] CH_SPACE = 8'h20;
  localparam logic [CW-1:0] CH_NL    = 8'h0A;

  typedef struct packed {
    logic word_push;
    logic cp_start;
    logic cp_append;
    logic cp_step;
    logic div_start;
    logic em_start;
    logic rd_issue;
    logic ld_char;
    logic pad_ld;
    logic ld_space;
    logic ld_nl;
    logic nl_fa;
    logic line_clear;
  } tlj_cmd_t;

  typedef struct packed {
    logic is_sep;
    logic wl_zero;
    logic ll_zero;
    logic fits;
    logic div_done;
    logic em_end;
    logic rd_space;
    logic pad_zero;
    logic slot_free;
    logic cp_done;
  } tlj_sts_t;

endpackage

// ===== design/tlj_ctrl.sv =====
// Sequencing state machine: word close, justified and final line emission.
module tlj_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_req_type,
  output logic              in_ready,
  input  tlj_pkg::tlj_sts_t sts,
  output tlj_pkg::tlj_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLOSE = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_CH    = 3'd4;
  localparam logic [2:0] S_PAD   = 3'd5;
  localparam logic [2:0] S_NL    = 3'd6;
  localparam logic [2:0] S_COPY  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       flush_r, flush_nxt;
  logic       just_r, just_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    flush_nxt = flush_r;
    just_nxt  = just_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_req_type && !sts.is_sep) begin
            cmd.word_push = 1'b1;
          end else begin
            flush_nxt = in_req_type;
            state_nxt = S_CLOSE;
          end
        end
      end
      S_CLOSE: begin
        if (sts.wl_zero) begin
          if (flush_r) begin
            just_nxt     = 1'b0;
            cmd.em_start = 1'b1;
            state_nxt    = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (sts.ll_zero || sts.fits) begin
          cmd.cp_start  = 1'b1;
          cmd.cp_append = !sts.ll_zero;
          just_nxt      = 1'b0;
          state_nxt     = S_COPY;
        end else begin
          // word does not fit: justify the held line first
          just_nxt      = 1'b1;
          cmd.div_start = 1'b1;
          cmd.em_start  = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (sts.em_end) begin
          state_nxt = S_NL;
        end else begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_CH;
        end
      end
      S_CH: begin
        if (sts.slot_free) begin
          cmd.ld_char = 1'b1;
          if (just_r && sts.rd_space) begin
            cmd.pad_ld = 1'b1;
            state_nxt  = S_PAD;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_PAD: begin
        if (sts.pad_zero) begin
          state_nxt = S_RD;
        end else if (sts.slot_free) begin
          cmd.ld_space = 1'b1;
        end
      end
      S_NL: begin
        if (sts.slot_free) begin
          cmd.ld_nl = 1'b1;
          cmd.nl_fa = flush_r && just_r;
          if (just_r) begin
            cmd.cp_start = 1'b1;
            state_nxt    = S_COPY;
          end else begin
            cmd.line_clear = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
      end
      S_COPY: begin
        cmd.cp_step = 1'b1;
        if (sts.cp_done) begin
          if (flush_r && !just_r) begin
            cmd.em_start = 1'b1;
            state_nxt    = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      flush_r <= 1'b0;
      just_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      flush_r <= flush_nxt;
      just_r  <= just_nxt;
    end
  end

endmodule

// ===== design/tlj_dp.sv =====
// Datapath: word and line stores, counters, gap divider and output register.
module tlj_dp #(
  parameter int MAX_WIDTH = tlj_pkg::MAX_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [tlj_pkg::CW-1:0]    in_char,
  input  logic                      cfg_wr_en,
  input  logic [tlj_pkg::LW-1:0]    cfg_line_width,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [tlj_pkg::CW-1:0]    out_char,
  output logic                      out_last_of_run,
  output logic                      out_flush_again,
  input  tlj_pkg::tlj_cmd_t         cmd,
  output tlj_pkg::tlj_sts_t         sts
);

  localparam int LW = tlj_pkg::LW;
  localparam int GW = tlj_pkg::GW;
  localparam int CW = tlj_pkg::CW;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int DCW = $clog2(LW + 1);
  localparam logic [LW-1:0] MAXW = LW'(MAX_WIDTH);

  logic [CW-1:0] word_mem [MAX_WIDTH];
  logic [CW-1:0] line_mem [MAX_WIDTH];

  logic [LW-1:0]  lw_r;
  logic [LW-1:0]  wl_r, ll_r;
  logic [GW-1:0]  gap_r;
  logic [LW-1:0]  cp_cnt_r, cp_len_r, cp_dst_r;
  logic           cp_pend_r;
  logic [CW-1:0]  wrd_r, lrd_r;
  logic [LW-1:0]  em_idx_r;
  logic [GW-1:0]  g_r;
  logic [LW:0]    pad_r;
  logic [LW-1:0]  dq_r, dr_r;
  logic [DCW-1:0] dcnt_r;
  logic           out_valid_r, out_last_r, out_fa_r;
  logic [CW-1:0]  out_char_r;

  logic [LW-1:0] ew, spare, trial;
  logic          slot_free, cp_more, extra;
  logic          lwe;
  logic [AW-1:0] lwa;
  logic [CW-1:0] lwd;

  always_comb begin
    if (lw_r < tlj_pkg::MIN_WIDTH) begin
      ew = tlj_pkg::MIN_WIDTH;
    end else if (lw_r > MAXW) begin
      ew = MAXW;
    end else begin
      ew = lw_r;
    end
  end

  assign spare     = (ew > ll_r) ? (ew - ll_r) : '0;
  assign slot_free = !out_valid_r || out_ready;
  assign cp_more   = (cp_cnt_r < cp_len_r);
  // remainder goes to the rightmost gaps
  assign extra     = (g_r >= (gap_r - dr_r[GW-1:0]));
  assign trial     = {dr_r[LW-2:0], dq_r[LW-1]};

  assign sts.is_sep    = (in_char == tlj_pkg::CH_SPACE) || (in_char == tlj_pkg::CH_NL);
  assign sts.wl_zero   = (wl_r == '0);
  assign sts.ll_zero   = (ll_r == '0);
  assign sts.fits      = ({1'b0, ll_r} + {1'b0, wl_r} + 7'd1) <= {1'b0, ew};
  assign sts.div_done  = (dcnt_r == '0);
  assign sts.em_end    = (em_idx_r == ll_r);
  assign sts.rd_space  = (lrd_r == tlj_pkg::CH_SPACE);
  assign sts.pad_zero  = (pad_r == '0);
  assign sts.slot_free = slot_free;
  assign sts.cp_done   = !cp_more && !cp_pend_r;

  // line store write port: separator space or copied word character
  always_comb begin
    lwe = 1'b0;
    lwa = '0;
    lwd = tlj_pkg::CH_SPACE;
    if (cmd.cp_start && cmd.cp_append) begin
      lwe = 1'b1;
      lwa = ll_r[AW-1:0];
    end else if (cp_pend_r) begin
      lwe = 1'b1;
      lwa = cp_dst_r[AW-1:0];
      lwd = wrd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.word_push && (wl_r < ew)) begin
      word_mem[wl_r[AW-1:0]] <= in_char;
    end
    if (cmd.cp_step && cp_more) begin
      wrd_r <= word_mem[cp_cnt_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (lwe) begin
      line_mem[lwa] <= lwd;
    end
    if (cmd.rd_issue) begin
      lrd_r <= line_mem[em_idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r        <= tlj_pkg::LINE_WIDTH_RST;
      wl_r        <= '0;
      ll_r        <= '0;
      gap_r       <= '0;
      cp_pend_r   <= 1'b0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        lw_r <= cfg_line_width;
      end
      if (cmd.word_push && (wl_r < ew)) begin
        wl_r <= wl_r + 1'b1;
      end
      if (cmd.cp_start) begin
        wl_r <= '0;
        if (cmd.cp_append) begin
          ll_r  <= ll_r + wl_r + 1'b1;
          gap_r <= gap_r + 1'b1;
        end else begin
          ll_r  <= wl_r;
          gap_r <= '0;
        end
      end else if (cmd.line_clear) begin
        ll_r  <= '0;
        gap_r <= '0;
      end
      cp_pend_r <= cmd.cp_step && cp_more;
      if (cmd.div_start) begin
        dcnt_r <= DCW'(LW);
      end else if (dcnt_r != '0) begin
        dcnt_r <= dcnt_r - 1'b1;
      end
      if (cmd.ld_char || cmd.ld_space || cmd.ld_nl) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cp_start) begin
      cp_cnt_r <= '0;
      cp_len_r <= wl_r;
      cp_dst_r <= cmd.cp_append ? (ll_r + 1'b1) : '0;
    end else begin
      if (cmd.cp_step && cp_more) begin
        cp_cnt_r <= cp_cnt_r + 1'b1;
      end
      if (cp_pend_r) begin
        cp_dst_r <= cp_dst_r + 1'b1;
      end
    end
    // restoring divide of spare by gap count, one quotient bit a cycle
    if (cmd.div_start) begin
      dq_r <= spare;
      dr_r <= '0;
    end else if (dcnt_r != '0) begin
      if (trial >= {1'b0, gap_r}) begin
        dr_r <= trial - {1'b0, gap_r};
        dq_r <= {dq_r[LW-2:0], 1'b1};
      end else begin
        dr_r <= trial;
        dq_r <= {dq_r[LW-2:0], 1'b0};
      end
    end
    if (cmd.em_start) begin
      em_idx_r <= '0;
      g_r      <= '0;
    end else begin
      if (cmd.rd_issue) begin
        em_idx_r <= em_idx_r + 1'b1;
      end
      if (cmd.pad_ld) begin
        g_r <= g_r + 1'b1;
      end
    end
    if (cmd.pad_ld) begin
      pad_r <= {1'b0, dq_r} + {{LW{1'b0}}, extra};
    end else if (cmd.ld_space) begin
      pad_r <= pad_r - 1'b1;
    end
    if (cmd.ld_char) begin
      out_char_r <= lrd_r;
      out_last_r <= 1'b0;
      out_fa_r   <= 1'b0;
    end else if (cmd.ld_space) begin
      out_char_r <= tlj_pkg::CH_SPACE;
      out_last_r <= 1'b0;
      out_fa_r   <= 1'b0;
    end else if (cmd.ld_nl) begin
      out_char_r <= tlj_pkg::CH_NL;
      out_last_r <= 1'b1;
      out_fa_r   <= cmd.nl_fa;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_last_of_run = out_last_r;
  assign out_flush_again = out_fa_r;

endmodule

// ===== design/text_line_justifier_top.sv =====
// Top level of the greedy full-justification block.
// Input channel (in_valid/in_ready): one beat per text byte (in_req_type 0)
// or a flush (in_req_type 1). Output channel (out_valid/out_ready): one beat
// per emitted byte; out_last_of_run marks the final byte of an input beat and
// out_flush_again asks the host for one more flush.
// cfg_line_width is written with cfg_wr_en only while the block is idle;
// this binds the user, as the block itself does not enforce it.
// A word character is stored in the word store. A separator or flush closes
// the word and copies a pending word onto the line, after a separator space
// when the line is not empty.
// A justified line first divides the spare width by the gap count (one
// quotient bit a cycle), then emits each line character, the padding spaces
// after each gap, and the newline; each line character is read from the
// single read port of the line store before it is loaded into the output
// register. A final line is emitted the same way without division or padding.
// Reset clears lengths, gap count and the output valid flag; width returns to
// 60. Store contents are not cleared and need no clearing pass.
// A stalled receiver holds the output register; the sequencer waits and no
// new beat is accepted until the current one has finished.
module text_line_justifier_top #(
  parameter int MAX_WIDTH = tlj_pkg::MAX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_req_type,
  input  logic [tlj_pkg::CW-1:0] in_char,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [tlj_pkg::CW-1:0] out_char,
  output logic                   out_last_of_run,
  output logic                   out_flush_again,
  input  logic                   cfg_wr_en,
  input  logic [tlj_pkg::LW-1:0] cfg_line_width
);

  tlj_pkg::tlj_cmd_t cmd;
  tlj_pkg::tlj_sts_t sts;

  tlj_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  tlj_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_char         (in_char),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_line_width  (cfg_line_width),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run),
    .out_flush_again (out_flush_again),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

// ===== design/tlj_checker.sv =====
// Port-level checks of the justifier, bound to the top level.
`include "text_line_justifier_top_macros.svh"

module tlj_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [tlj_pkg::CW-1:0] out_char,
  input logic                   out_last_of_run,
  input logic                   out_flush_again
);

  `TLJ_ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_char), "output beat dropped or changed while stalled")
  `TLJ_ASSERT_IMPL(a_fa_last, clk, rst_n, out_valid && out_flush_again, out_last_of_run, "flush_again off the last beat")
  `TLJ_ASSERT_IMPL(a_last_nl, clk, rst_n, out_valid && out_last_of_run, out_char == tlj_pkg::CH_NL, "run does not end in newline")
  `TLJ_ASSERT_CLK(a_busy_cause, clk, rst_n, $fell(in_ready) |-> $past(in_valid && in_ready), "went busy without an accepted beat")

endmodule

bind text_line_justifier_top tlj_checker u_tlj_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_char        (out_char),
  .out_last_of_run (out_last_of_run),
  .out_flush_again (out_flush_again)
);
